// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is also checked across reset.
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/trqr_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle radius ratio package
// Widths and constants shared by the radius ratio pipeline.
// ----------------------------------------------------------------------------
package trqr_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned SQ_W     = 2 * DIFF_W;
  localparam int unsigned ROOT_W   = 34;
  localparam int unsigned EDGE_W   = 33;
  localparam int unsigned SIDE_W   = EDGE_W + 2;
  localparam int unsigned SIDEU_W  = EDGE_W + 1;
  localparam int unsigned ABC_W    = 3 * EDGE_W;
  localparam int unsigned DEN_W    = 3 * SIDEU_W;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned SQRT_LAT = ROOT_W;
  localparam int unsigned DIV_LAT  = QUO_W + 1;

  typedef logic [DIFF_W-1:0] diff_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [EDGE_W-1:0] edge_t;

endpackage

// ===== rtl/trqr_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module trqr_isqrt #(
  parameter int unsigned RW = 34
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int unsigned RMW = RW + 2;

  logic [2*RW-1:0] opd_r   [RW];
  logic [RMW-1:0]  rem_r   [RW];
  logic [RW-1:0]   root_r  [RW];
  logic [2*RW-1:0] opd_nxt [RW];
  logic [RMW-1:0]  rem_nxt [RW];
  logic [RW-1:0]   root_nxt[RW];

  always_comb begin
    logic [2*RW-1:0] s_opd;
    logic [RMW-1:0]  s_rem;
    logic [RW-1:0]   s_root;
    logic [RMW+1:0]  cat;
    logic [RMW+1:0]  trial;
    logic            ge;
    for (int i = 0; i < int'(RW); i++) begin
      if (i == 0) begin
        s_opd  = rad;
        s_rem  = '0;
        s_root = '0;
      end else begin
        s_opd  = opd_r[i-1];
        s_rem  = rem_r[i-1];
        s_root = root_r[i-1];
      end
      cat   = {s_rem, s_opd[2*RW-1 -: 2]};
      trial = (RMW + 2)'({s_root, 2'b01});
      ge    = (cat >= trial);
      rem_nxt[i]  = ge ? RMW'(cat - trial) : RMW'(cat);
      root_nxt[i] = {s_root[RW-2:0], ge};
      opd_nxt[i]  = {s_opd[2*RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < int'(RW); i++) begin
        opd_r[i]  <= opd_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

// ===== rtl/trqr_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Restoring division, one quotient bit per stage, saturating at all ones.
// ----------------------------------------------------------------------------
module trqr_div #(
  parameter int unsigned NW = 116,
  parameter int unsigned DW = 102,
  parameter int unsigned QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          force_sat,
  input  logic          tag_in,
  output logic [QW-1:0] quo,
  output logic          tag_out
);

  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          sat_r [QW+1];
  logic          tag_r [QW+1];
  logic [DW-1:0] rem_nxt[QW];
  logic [QW-1:0] q_nxt  [QW];
  logic [DW-1:0] hi_ext;

  assign hi_ext = DW'(num[NW-1:QW]);

  always_comb begin
    logic [DW:0] cat;
    logic        ge;
    for (int j = 0; j < int'(QW); j++) begin
      cat = {rem_r[j], lo_r[j][QW-1]};
      ge  = (cat >= {1'b0, den_r[j]});
      rem_nxt[j] = ge ? DW'(cat - {1'b0, den_r[j]}) : DW'(cat);
      q_nxt[j]   = {q_r[j][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext;
      den_r[0] <= den;
      lo_r[0]  <= num[QW-1:0];
      q_r[0]   <= '0;
      sat_r[0] <= force_sat || (hi_ext >= den);
      tag_r[0] <= tag_in;
      for (int j = 0; j < int'(QW); j++) begin
        rem_r[j+1] <= rem_nxt[j];
        den_r[j+1] <= den_r[j];
        lo_r[j+1]  <= {lo_r[j][QW-2:0], 1'b0};
        q_r[j+1]   <= q_nxt[j];
        sat_r[j+1] <= sat_r[j];
        tag_r[j+1] <= tag_r[j];
      end
    end
  end

  assign quo     = sat_r[QW] ? '1 : q_r[QW];
  assign tag_out = tag_r[QW];

endmodule

// ===== rtl/triangle_radius_ratio_quality_unit.sv =====
// Throughput: one triangle per cycle; the whole pipeline holds while a result is stalled.
// Most of the pipeline lies in the two bit-per-stage units: 34 square root stages and 33 divider stages.
// Reset clears only the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Triangle radius ratio quality unit
// Computes circumradius over inradius of a 3D triangle as unsigned fixed point.
// ----------------------------------------------------------------------------
module triangle_radius_ratio_quality_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_ax,
  input  logic [31:0] in_ay,
  input  logic [31:0] in_az,
  input  logic [31:0] in_bx,
  input  logic [31:0] in_by_coord,
  input  logic [31:0] in_bz,
  input  logic [31:0] in_cx,
  input  logic [31:0] in_cy,
  input  logic [31:0] in_cz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_ratio,
  output logic        out_degenerate
);

  localparam int unsigned LAT = 7 + trqr_pkg::SQRT_LAT + trqr_pkg::DIV_LAT;
  localparam int unsigned NW  = trqr_pkg::ABC_W + FRAC_BITS + 1;
  localparam int unsigned EW  = trqr_pkg::EDGE_W;
  localparam int unsigned SUW = trqr_pkg::SIDEU_W;

  logic                     en;
  logic [LAT-1:0]           vld_r;
  logic [31:0]              co [9];
  trqr_pkg::diff_t          dif_nxt [9];
  trqr_pkg::diff_t          dif_r [9];
  trqr_pkg::sq_t            sq_r [9];
  trqr_pkg::sq_t            ssum_r [3];
  logic [trqr_pkg::ROOT_W-1:0] root [3];
  trqr_pkg::edge_t          ea_r, eb_r, ec_r, ec5_r;
  logic [trqr_pkg::SIDE_W-1:0] sx, sy, sz;
  logic [SUW-1:0]           x_r, y_r, z_r, z5_r;
  logic                     dg4_r, dg5_r, dg6_r, dg7_r, dg_nxt;
  logic [2*EW-1:0]          ab_r;
  logic [2*SUW-1:0]         xy_r;
  logic [2*EW-1:0]          pabl_r, pabh_r;
  logic [2*SUW-1:0]         pxyl_r, pxyh_r;
  logic [NW-1:0]            num_r;
  logic [trqr_pkg::DEN_W-1:0] den_r;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign co[0] = in_ax;
  assign co[1] = in_ay;
  assign co[2] = in_az;
  assign co[3] = in_bx;
  assign co[4] = in_by_coord;
  assign co[5] = in_bz;
  assign co[6] = in_cx;
  assign co[7] = in_cy;
  assign co[8] = in_cz;

  always_comb begin
    logic [trqr_pkg::DIFF_W-1:0] d;
    int p;
    for (int e = 0; e < 3; e++) begin
      p = (e == 2) ? 0 : e + 1;
      for (int k = 0; k < 3; k++) begin
        d = {co[3*p+k][31], co[3*p+k]} - {co[3*e+k][31], co[3*e+k]};
        dif_nxt[3*e+k] = d[trqr_pkg::DIFF_W-1] ? -d : d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        dif_r[i] <= dif_nxt[i];
        sq_r[i]  <= dif_r[i] * dif_r[i];
      end
      for (int e = 0; e < 3; e++) begin
        ssum_r[e] <= sq_r[3*e] + sq_r[3*e+1] + sq_r[3*e+2];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_sqrt
    trqr_isqrt #(
      .RW(trqr_pkg::ROOT_W)
    ) u_isqrt (
      .clk (clk),
      .en  (en),
      .rad ({2'b00, ssum_r[g]}),
      .root(root[g])
    );
  end

  assign sx = {2'b00, root[1][EW-1:0]} + {2'b00, root[2][EW-1:0]} - {2'b00, root[0][EW-1:0]};
  assign sy = {2'b00, root[2][EW-1:0]} + {2'b00, root[0][EW-1:0]} - {2'b00, root[1][EW-1:0]};
  assign sz = {2'b00, root[0][EW-1:0]} + {2'b00, root[1][EW-1:0]} - {2'b00, root[2][EW-1:0]};
  assign dg_nxt = sx[trqr_pkg::SIDE_W-1] || (sx == '0) || sy[trqr_pkg::SIDE_W-1] ||
                  (sy == '0) || sz[trqr_pkg::SIDE_W-1] || (sz == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      ea_r   <= root[0][EW-1:0];
      eb_r   <= root[1][EW-1:0];
      ec_r   <= root[2][EW-1:0];
      x_r    <= sx[SUW-1:0];
      y_r    <= sy[SUW-1:0];
      z_r    <= sz[SUW-1:0];
      dg4_r  <= dg_nxt;
      ab_r   <= ea_r * eb_r;
      xy_r   <= x_r * y_r;
      ec5_r  <= ec_r;
      z5_r   <= z_r;
      dg5_r  <= dg4_r;
      pabl_r <= ab_r[EW-1:0] * ec5_r;
      pabh_r <= ab_r[2*EW-1:EW] * ec5_r;
      pxyl_r <= xy_r[SUW-1:0] * z5_r;
      pxyh_r <= xy_r[2*SUW-1:SUW] * z5_r;
      dg6_r  <= dg5_r;
      num_r  <= NW'((trqr_pkg::ABC_W'(pabh_r) << EW) + trqr_pkg::ABC_W'(pabl_r))
                << (FRAC_BITS + 1);
      den_r  <= (trqr_pkg::DEN_W'(pxyh_r) << SUW) + trqr_pkg::DEN_W'(pxyl_r);
      dg7_r  <= dg6_r;
    end
  end

  trqr_div #(
    .NW(NW),
    .DW(trqr_pkg::DEN_W),
    .QW(trqr_pkg::QUO_W)
  ) u_div (
    .clk      (clk),
    .en       (en),
    .num      (num_r),
    .den      (den_r),
    .force_sat(dg7_r),
    .tag_in   (dg7_r),
    .quo      (out_ratio),
    .tag_out  (out_degenerate)
  );

  assign out_valid = vld_r[LAT-1];

endmodule

// ===== rtl/trqr_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle radius ratio checker
// Port-level assertions on the radius ratio unit, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trqr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_ax,
  input logic [31:0] in_ay,
  input logic [31:0] in_az,
  input logic [31:0] in_bx,
  input logic [31:0] in_by_coord,
  input logic [31:0] in_bz,
  input logic [31:0] in_cx,
  input logic [31:0] in_cy,
  input logic [31:0] in_cz,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_ratio,
  input logic        out_degenerate
);

  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "Stalled result was dropped.")
  `ASSERT_RST(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_ratio) && $stable(out_degenerate), "Stalled result changed.")
  `ASSERT_RST(a_degen_sat, clk, rst_n, out_valid && out_degenerate |-> out_ratio == 32'hFFFF_FFFF, "Degenerate result is not saturated.")
  `ASSERT_RST(a_stall_back, clk, rst_n, in_stall == (out_valid && out_stall), "Input stalled without a stalled result.")
  `ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid, "Result valid straight after reset.")

endmodule

bind triangle_radius_ratio_quality_unit trqr_checker u_trqr_checker (.*);

// ===== dv/triangle_radius_ratio_quality_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle radius ratio quality unit testbench
// Streams directed and random triangles through the unit, predicts the
// circumradius to inradius ratio and the degenerate flag of each one, and
// compares every result transfer in order, under random idling and a long
// hold-off on the result side.
// ----------------------------------------------------------------------------
module triangle_radius_ratio_quality_unit_tb;

  localparam int unsigned FRAC = 16;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] ratio;
    logic        degenerate;
  } quality_t;

  typedef logic [8:0][31:0] tri_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz, in_cx, in_cy, in_cz;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_ratio;
  logic        out_degenerate;

  quality_t pending_q[$];
  int       mismatches;
  int       idle_cycles;
  int       burst_left;
  int       stall_pct;
  bit       hold_req;

  triangle_radius_ratio_quality_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by_coord(in_by_coord), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ratio(out_ratio), .out_degenerate(out_degenerate)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [33:0] edge_length(logic [31:0] p0, p1, p2, q0, q1, q2);
    logic signed [32:0] d;
    logic [32:0]        m;
    logic [67:0]        sum;
    logic [67:0]        sq;
    logic [33:0]        r;
    logic [33:0]        t;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: d = $signed({p0[31], p0}) - $signed({q0[31], q0});
        1: d = $signed({p1[31], p1}) - $signed({q1[31], q1});
        default: d = $signed({p2[31], p2}) - $signed({q2[31], q2});
      endcase
      m = d[32] ? 33'(-d) : 33'(d);
      sum = sum + {35'b0, m} * {35'b0, m};
    end
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      t = r | (34'd1 << i);
      sq = {34'b0, t} * {34'b0, t};
      if (sq <= sum) begin
        r = t;
      end
    end
    return r;
  endfunction

  function automatic quality_t predict_quality(tri_t v);
    logic [33:0]        a, b, c;
    logic signed [35:0] x, y, z;
    logic [129:0]       num, den, quo;
    quality_t           res;
    a = edge_length(v[3], v[4], v[5], v[0], v[1], v[2]);
    b = edge_length(v[6], v[7], v[8], v[3], v[4], v[5]);
    c = edge_length(v[0], v[1], v[2], v[6], v[7], v[8]);
    x = $signed({2'b0, b}) + $signed({2'b0, c}) - $signed({2'b0, a});
    y = $signed({2'b0, c}) + $signed({2'b0, a}) - $signed({2'b0, b});
    z = $signed({2'b0, a}) + $signed({2'b0, b}) - $signed({2'b0, c});
    if (x <= 0 || y <= 0 || z <= 0) begin
      res.ratio = 32'hFFFF_FFFF;
      res.degenerate = 1'b1;
    end else begin
      num = ({96'b0, a} * {96'b0, b} * {96'b0, c}) << (FRAC + 1);
      den = {94'b0, x} * {94'b0, y} * {94'b0, z};
      quo = num / den;
      res.ratio = (quo > 130'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
      res.degenerate = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_triangle(input tri_t v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_ax <= v[0]; in_ay <= v[1]; in_az <= v[2];
    in_bx <= v[3]; in_by_coord <= v[4]; in_bz <= v[5];
    in_cx <= v[6]; in_cy <= v[7]; in_cz <= v[8];
    do @(posedge clk); while (in_stall);
    pending_q = {pending_q, predict_quality(v)};
  endtask

  function automatic tri_t small_triangle(int unsigned span);
    tri_t v;
    for (int i = 0; i < 9; i++) begin
      v[i] = 32'($signed($urandom_range(2 * span)) - $signed(span));
    end
    return v;
  endfunction

  task automatic test_directed();
    tri_t v;
    v = '0;
    send_triangle(v);
    v = {32'd0, 32'd56756, 32'd32768, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0};
    send_triangle(v);
    v = {32'd0, 32'd0, 32'd4, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0, 32'd0};
    send_triangle(v);
    v = {32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0};
    send_triangle(v);
    v = {32'd0, 32'd1, 32'd500000, 32'd0, 32'd0, 32'd1000000, 32'd0, 32'd0, 32'd0};
    send_triangle(v);
    v = {32'd0, 32'd3000, 32'd500000, 32'd0, 32'd0, 32'd1000000, 32'd0, 32'd0, 32'd0};
    send_triangle(v);
    v = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_triangle(v);
    v = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    send_triangle(v);
    v = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_triangle(v);
    v = {32'd3, 32'd3, 32'd3, 32'd2, 32'd2, 32'd2, 32'd1, 32'd1, 32'd1};
    send_triangle(v);
    v = {32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0};
    send_triangle(v);
    v = {32'd1, 32'd1, 32'd2, 32'd1, 32'd2, 32'd1, 32'd2, 32'd1, 32'd1};
    send_triangle(v);
    v = {32'd0, 32'd0, 32'd2, 32'd0, 32'd2, 32'd0, 32'd2, 32'd0, 32'd0};
    send_triangle(v);
    v = {32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0};
    send_triangle(v);
  endtask

  task automatic test_random_small(int n);
    for (int i = 0; i < n; i++) begin
      send_triangle(small_triangle($urandom_range(3) == 0 ? 16 : 1 << 20));
    end
  endtask

  task automatic test_random_full(int n);
    tri_t v;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 9; j++) begin
        v[j] = $urandom();
      end
      send_triangle(v);
    end
  endtask

  task automatic test_slivers(int n);
    tri_t v;
    for (int i = 0; i < n; i++) begin
      v = small_triangle(1 << 18);
      for (int j = 0; j < 3; j++) begin
        v[6 + j] = v[j] + ((v[3 + j] - v[j]) >>> $urandom_range(1, 4))
                   + 32'($signed($urandom_range(4)) - 2);
      end
      send_triangle(v);
    end
  endtask

  task automatic test_backpressure(int n);
    hold_req = 1'b1;
    test_random_small(n);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result transfer", out_ratio, 32'h0);
      end else begin
        quality_t want;
        want = pending_q.pop_front();
        if (out_ratio !== want.ratio) begin
          report_mismatch("ratio", out_ratio, want.ratio);
        end
        if (out_degenerate !== want.degenerate) begin
          report_mismatch("degenerate", {31'b0, out_degenerate}, {31'b0, want.degenerate});
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz, in_cx, in_cy, in_cz} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_pct = 30;
    test_random_small(300);
    stall_pct = 0;
    test_random_full(150);
    stall_pct = 50;
    test_slivers(200);
    stall_pct = 20;
    test_backpressure(150);
    stall_pct = 10;
    test_random_full(140);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
